// File: sv/vector3_alu_normalize_top_defines.svh
// assertion macros for the vector alu checker
// needs clk and rst_n in scope, and PIPE_LAT from v3alu_pkg
`ifndef VECTOR3_ALU_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_ALU_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication
`define V3ALU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v3alu assertion failed");

// implication across the full pipeline latency
`define V3ALU_ASSERT_LAT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##PIPE_LAT (cons)) else $error("v3alu latency assertion failed");

`endif

// File: sv/v3alu_pkg.sv
// shared types, codes and helpers of the vector alu
// no dependencies
package v3alu_pkg;

    localparam logic [2:0] KIND_ADD       = 3'd0;
    localparam logic [2:0] KIND_SUB       = 3'd1;
    localparam logic [2:0] KIND_SCALE     = 3'd2;
    localparam logic [2:0] KIND_DOT       = 3'd3;
    localparam logic [2:0] KIND_CROSS     = 3'd4;
    localparam logic [2:0] KIND_NORM      = 3'd5;
    localparam logic [2:0] KIND_NORMALIZE = 3'd6;

    localparam int Q_BITS     = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int PIPE_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] factor;
    } v3alu_cmd_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_out;
        logic               saturated;
    } v3alu_res_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        v3alu_res_t         res;
    } v3alu_carry_t;

    typedef struct packed {
        logic signed [63:0] p_dot;
        logic signed [63:0] p_scale;
        logic signed [63:0] p_cr1;
        logic signed [63:0] p_cr2;
        logic [63:0]        p_sq;
    } v3alu_prod_t;

    // saturate to 32 bits, returns {clipped, value}
    function automatic logic [32:0] clip32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7fff_ffff};
        end
        if (v < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// File: sv/v3alu_lane.sv
// one element lane: registered products for dot, scale, cross and sum of squares
// depends on v3alu_pkg
module v3alu_lane
    import v3alu_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a_i,
    input  logic signed [31:0] b_i,
    input  logic signed [31:0] a_p1,
    input  logic signed [31:0] b_p1,
    input  logic signed [31:0] a_p2,
    input  logic signed [31:0] b_p2,
    input  logic signed [31:0] factor,
    output v3alu_prod_t        prod_reg
);

    v3alu_prod_t prod_next;
    logic [31:0] mag;

    always_comb
    begin
        mag               = abs32(a_i);
        prod_next.p_dot   = 64'(a_i) * 64'(b_i);
        prod_next.p_scale = 64'(a_i) * 64'(factor);
        prod_next.p_cr1   = 64'(a_p1) * 64'(b_p2);
        prod_next.p_cr2   = 64'(a_p2) * 64'(b_p1);
        prod_next.p_sq    = 64'(mag) * 64'(mag);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// File: sv/v3alu_merge.sv
// merge stage: finishes add, sub, scale, cross and dot results and sums the squares
// depends on v3alu_pkg
module v3alu_merge
    import v3alu_pkg::*;
(
    input  logic                   clk,
    input  v3alu_cmd_t             cmd,
    input  v3alu_prod_t [2:0]      prod,
    output v3alu_carry_t           carry_reg,
    output logic [63:0]            sumsq_reg
);

    v3alu_carry_t       carry_next;
    logic [63:0]        sumsq_next;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic [32:0]        c [3];
    logic [32:0]        cd;
    logic signed [65:0] dsum;
    logic signed [65:0] cdiff [3];
    logic signed [63:0] sc [3];
    logic [31:0]        r [3];

    always_comb
    begin
        a[0] = cmd.ax; a[1] = cmd.ay; a[2] = cmd.az;
        b[0] = cmd.bx; b[1] = cmd.by; b[2] = cmd.bz;
        dsum = 66'(prod[0].p_dot) + 66'(prod[1].p_dot) + 66'(prod[2].p_dot);
        cd   = clip32(dsum >>> Q_BITS);
        for (int i = 0; i < 3; i++)
        begin
            cdiff[i] = 66'(prod[i].p_cr1) - 66'(prod[i].p_cr2);
            sc[i]    = prod[i].p_scale >>> Q_BITS;
            case (cmd.kind)
                KIND_ADD:   c[i] = clip32(66'(a[i]) + 66'(b[i]));
                KIND_SUB:   c[i] = clip32(66'(a[i]) - 66'(b[i]));
                KIND_SCALE: c[i] = clip32(66'(sc[i]));
                KIND_CROSS: c[i] = clip32(cdiff[i] >>> Q_BITS);
                default:    c[i] = 33'd0;
            endcase
            r[i] = c[i][31:0];
        end
        sumsq_next = prod[0].p_sq + prod[1].p_sq + prod[2].p_sq;

        carry_next.kind = cmd.kind;
        carry_next.ax   = cmd.ax;
        carry_next.ay   = cmd.ay;
        carry_next.az   = cmd.az;
        carry_next.res.rx = r[0];
        carry_next.res.ry = r[1];
        carry_next.res.rz = r[2];
        if (cmd.kind == KIND_DOT)
        begin
            carry_next.res.scalar_out = cd[31:0];
            carry_next.res.saturated  = cd[32];
        end
        else
        begin
            carry_next.res.scalar_out = 32'sd0;
            carry_next.res.saturated  = c[0][32] | c[1][32] | c[2][32];
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        sumsq_reg <= sumsq_next;
    end

endmodule

// File: sv/v3alu_sqrt_step.sv
// one registered step of the floor square root
// depends on v3alu_pkg
module v3alu_sqrt_step
    import v3alu_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    input  v3alu_carry_t carry_in,
    input  logic [63:0]  x_in,
    input  logic [63:0]  root_in,
    output logic         valid_reg,
    output v3alu_carry_t carry_reg,
    output logic [63:0]  x_reg,
    output logic [63:0]  root_reg
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic [63:0] x_next;
    logic [63:0] root_next;

    always_comb
    begin
        trial = root_in + BIT;
        if (x_in >= trial)
        begin
            x_next    = x_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            x_next    = x_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_in;
        x_reg     <= x_next;
        root_reg  <= root_next;
    end

endmodule

// File: sv/v3alu_div_step.sv
// one registered quotient bit of the three normalize dividers
// depends on v3alu_pkg
module v3alu_div_step
    import v3alu_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  v3alu_carry_t      carry_in,
    input  logic [31:0]       n_in,
    input  logic [2:0][47:0]  rem_in,
    input  logic [2:0][16:0]  quo_in,
    output logic              valid_reg,
    output v3alu_carry_t      carry_reg,
    output logic [31:0]       n_reg,
    output logic [2:0][47:0]  rem_reg,
    output logic [2:0][16:0]  quo_reg
);

    logic [48:0]      dsh;
    logic [2:0][47:0] rem_next;
    logic [2:0][16:0] quo_next;

    always_comb
    begin
        dsh = 49'(n_in) << SHIFT;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = rem_in[i];
            quo_next[i] = quo_in[i];
            if (49'(rem_in[i]) >= dsh)
            begin
                rem_next[i]        = rem_in[i] - dsh[47:0];
                quo_next[i][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_in;
        n_reg     <= n_in;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

endmodule

// File: sv/vector3_alu_normalize_top.sv
// top level of the q16.16 three-component vector alu
// depends on v3alu_pkg, v3alu_lane, v3alu_merge, v3alu_sqrt_step, v3alu_div_step
//
//  channel   handshake        payload       direction
//  command   start / busy     cmd           in
//  result    done (strobe)    result        out
//
//  an item is accepted every cycle; busy is always low
//  each result shows on done after its item has passed, in order, through the
//  input register, lane multipliers, merge, 32 square root steps,
//  17 quotient steps of the normalize dividers, output register
//  every operation runs the full pipeline, so results keep item order
//  rst_n clears all valid flags asynchronously; the receiver cannot stall
module vector3_alu_normalize_top
    import v3alu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  v3alu_cmd_t cmd,
    output logic       done,
    output v3alu_res_t result
);

    // input register
    logic       in_valid_reg;
    v3alu_cmd_t in_cmd_reg;
    // lane stage
    logic       s1_valid_reg;
    v3alu_cmd_t s1_cmd_reg;
    v3alu_prod_t [2:0] prod;
    logic signed [31:0] a_vec [3];
    logic signed [31:0] b_vec [3];
    // merge stage
    logic         s2_valid_reg;
    // square root chain, entry zero is the merge output
    logic         sq_valid [SQRT_STEPS+1];
    v3alu_carry_t sq_carry [SQRT_STEPS+1];
    logic [63:0]  sq_x     [SQRT_STEPS+1];
    logic [63:0]  sq_root  [SQRT_STEPS+1];
    // divider chain
    logic             dv_valid [DIV_STEPS+1];
    v3alu_carry_t     dv_carry [DIV_STEPS+1];
    logic [31:0]      dv_n     [DIV_STEPS+1];
    logic [2:0][47:0] dv_rem   [DIV_STEPS+1];
    logic [2:0][16:0] dv_quo   [DIV_STEPS+1];
    // output
    logic       done_reg;
    v3alu_res_t result_reg;
    v3alu_res_t result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            s1_valid_reg <= in_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= dv_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_cmd_reg <= cmd;
        end
        s1_cmd_reg <= in_cmd_reg;
        result_reg <= result_next;
    end

    always_comb
    begin
        a_vec[0] = in_cmd_reg.ax; a_vec[1] = in_cmd_reg.ay; a_vec[2] = in_cmd_reg.az;
        b_vec[0] = in_cmd_reg.bx; b_vec[1] = in_cmd_reg.by; b_vec[2] = in_cmd_reg.bz;
    end

    // one lane per element; cross terms use the other two elements
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int P1 = (i + 1) % 3;
        localparam int P2 = (i + 2) % 3;
        v3alu_lane u_lane (
            .clk      (clk),
            .a_i      (a_vec[i]),
            .b_i      (b_vec[i]),
            .a_p1     (a_vec[P1]),
            .b_p1     (b_vec[P1]),
            .a_p2     (a_vec[P2]),
            .b_p2     (b_vec[P2]),
            .factor   (in_cmd_reg.factor),
            .prod_reg (prod[i])
        );
    end

    // dot sum, cross, scale, add and sub finish here; sum of squares goes on
    v3alu_merge u_merge (
        .clk       (clk),
        .cmd       (s1_cmd_reg),
        .prod      (prod),
        .carry_reg (sq_carry[0]),
        .sumsq_reg (sq_x[0])
    );

    assign sq_valid[0] = s2_valid_reg;
    assign sq_root[0]  = 64'd0;

    // floor square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        v3alu_sqrt_step #(.STEP(k)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[k]),
            .carry_in  (sq_carry[k]),
            .x_in      (sq_x[k]),
            .root_in   (sq_root[k]),
            .valid_reg (sq_valid[k+1]),
            .carry_reg (sq_carry[k+1]),
            .x_reg     (sq_x[k+1]),
            .root_reg  (sq_root[k+1])
        );
    end

    // divider load: dividend is |a_i| shifted up by the fraction width
    assign dv_valid[0] = sq_valid[SQRT_STEPS];
    assign dv_carry[0] = sq_carry[SQRT_STEPS];
    assign dv_n[0]     = sq_root[SQRT_STEPS][31:0];
    always_comb
    begin
        dv_rem[0][0] = {abs32(sq_carry[SQRT_STEPS].ax), 16'd0};
        dv_rem[0][1] = {abs32(sq_carry[SQRT_STEPS].ay), 16'd0};
        dv_rem[0][2] = {abs32(sq_carry[SQRT_STEPS].az), 16'd0};
        dv_quo[0]    = '0;
    end

    // quotient never exceeds one, so 17 bits cover it
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        v3alu_div_step #(.SHIFT(DIV_STEPS - 1 - j)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[j]),
            .carry_in  (dv_carry[j]),
            .n_in      (dv_n[j]),
            .rem_in    (dv_rem[j]),
            .quo_in    (dv_quo[j]),
            .valid_reg (dv_valid[j+1]),
            .carry_reg (dv_carry[j+1]),
            .n_reg     (dv_n[j+1]),
            .rem_reg   (dv_rem[j+1]),
            .quo_reg   (dv_quo[j+1])
        );
    end

    // final fix-up for norm and normalize
    always_comb
    begin
        logic [32:0]        cn;
        logic [31:0]        q   [3];
        logic signed [31:0] av  [3];
        logic [31:0]        rv  [3];
        cn    = clip32(66'({1'b0, dv_n[DIV_STEPS]}));
        av[0] = dv_carry[DIV_STEPS].ax;
        av[1] = dv_carry[DIV_STEPS].ay;
        av[2] = dv_carry[DIV_STEPS].az;
        for (int i = 0; i < 3; i++)
        begin
            q[i]  = 32'(dv_quo[DIV_STEPS][i]);
            // truncation toward zero: negate the magnitude quotient
            rv[i] = av[i][31] ? 32'(-q[i]) : q[i];
        end
        result_next = dv_carry[DIV_STEPS].res;
        case (dv_carry[DIV_STEPS].kind)
            KIND_NORM:
            begin
                result_next.scalar_out = cn[31:0];
                result_next.saturated  = cn[32];
            end
            KIND_NORMALIZE:
            begin
                // zero vector passes through as zeros
                if (dv_n[DIV_STEPS] != 32'd0)
                begin
                    result_next.rx = rv[0];
                    result_next.ry = rv[1];
                    result_next.rz = rv[2];
                end
            end
            default:
            begin
                result_next = dv_carry[DIV_STEPS].res;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/v3alu_checker.sv
// port-level checks of the vector alu, bound to the top level
// depends on v3alu_pkg and vector3_alu_normalize_top_defines.svh
`include "vector3_alu_normalize_top_defines.svh"

module v3alu_checker
    import v3alu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input v3alu_cmd_t cmd,
    input logic       done,
    input v3alu_res_t result
);

    `V3ALU_ASSERT_IMP(a_no_busy, 1'b1, !busy)
    `V3ALU_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, PIPE_LAT))
    `V3ALU_ASSERT_LAT(a_norm_vec_zero, start && !busy && cmd.kind == KIND_NORM, done && result.rx == 32'sd0 && result.ry == 32'sd0 && result.rz == 32'sd0)
    `V3ALU_ASSERT_LAT(a_normalize_nosat, start && !busy && cmd.kind == KIND_NORMALIZE, done && !result.saturated && result.scalar_out == 32'sd0)

endmodule

bind vector3_alu_normalize_top v3alu_checker u_v3alu_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench of the q16.16 vector alu: directed and random items, own predictor
// depends on v3alu_pkg and vector3_alu_normalize_top
module tb;
    import v3alu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    v3alu_cmd_t cmd;
    logic       done;
    v3alu_res_t result;

    // items waiting to be driven, and results predicted for items already taken
    v3alu_cmd_t pending_items[$];
    v3alu_res_t predicted_results[$];
    int         fail_count;
    bit         stim_loaded;
    int         gap_left;

    vector3_alu_normalize_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // saturate an exact value to 32 bits, raising the flag when clipped
    function automatic logic signed [31:0] sat32(input logic signed [127:0] v, inout bit hit);
        if (v > 128'sd2147483647)
        begin
            hit = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sd2147483648)
        begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor square root of a 66-bit value, bit by bit
    function automatic logic [63:0] root_floor(input logic [65:0] x);
        logic [65:0] root;
        logic [65:0] trial;
        root = '0;
        for (int k = 32; k >= 0; k--)
        begin
            trial = root | (66'd1 << k);
            if (trial * trial <= x)
                root = trial;
        end
        return root[63:0];
    endfunction

    // expected result of one item; every product and sum is exact at 128 bits,
    // so the arithmetic shift right by 16 is a floor division
    function automatic v3alu_res_t vec_outcome(input v3alu_cmd_t c);
        v3alu_res_t         r;
        bit                 hit;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] f;
        logic signed [127:0] acc;
        logic [65:0]         sq;
        logic [63:0]         len;
        r = '0;
        hit = 1'b0;
        a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
        b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
        f = c.factor;
        sq = '0;
        for (int i = 0; i < 3; i++)
            sq += 66'(a[i] * a[i]);
        len = root_floor(sq);
        case (c.kind)
            KIND_ADD:
            begin
                r.rx = sat32(a[0] + b[0], hit);
                r.ry = sat32(a[1] + b[1], hit);
                r.rz = sat32(a[2] + b[2], hit);
            end
            KIND_SUB:
            begin
                r.rx = sat32(a[0] - b[0], hit);
                r.ry = sat32(a[1] - b[1], hit);
                r.rz = sat32(a[2] - b[2], hit);
            end
            KIND_SCALE:
            begin
                r.rx = sat32((a[0] * f) >>> 16, hit);
                r.ry = sat32((a[1] * f) >>> 16, hit);
                r.rz = sat32((a[2] * f) >>> 16, hit);
            end
            KIND_DOT:
            begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                r.scalar_out = sat32(acc >>> 16, hit);
            end
            KIND_CROSS:
            begin
                r.rx = sat32((a[1] * b[2] - a[2] * b[1]) >>> 16, hit);
                r.ry = sat32((a[2] * b[0] - a[0] * b[2]) >>> 16, hit);
                r.rz = sat32((a[0] * b[1] - a[1] * b[0]) >>> 16, hit);
            end
            KIND_NORM:
                r.scalar_out = sat32({64'd0, len}, hit);
            KIND_NORMALIZE:
            begin
                // truncating division; zero vector stays zero
                if (len != 0)
                begin
                    acc = (a[0] <<< 16) / $signed({64'd0, len});
                    r.rx = acc[31:0];
                    acc = (a[1] <<< 16) / $signed({64'd0, len});
                    r.ry = acc[31:0];
                    acc = (a[2] <<< 16) / $signed({64'd0, len});
                    r.rz = acc[31:0];
                end
            end
            default:
                r = '0;
        endcase
        r.saturated = hit;
        return r;
    endfunction

    // random 32-bit field: full range, small or extreme values, about a third each
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic v3alu_cmd_t make_item(input logic [2:0] k, input logic [31:0] w);
        v3alu_cmd_t c;
        c.kind = k;
        c.ax = w; c.ay = w; c.az = w;
        c.bx = w; c.by = w; c.bz = w;
        c.factor = w;
        return c;
    endfunction

    // stimulus: directed corners, then random items
    initial
    begin
        v3alu_cmd_t c;
        rst_n = 1'b0;
        stim_loaded = 1'b0;
        fail_count = 0;
        // every kind, including unused code 7, at both extremes
        for (int k = 0; k < 8; k++)
        begin
            pending_items.push_back(make_item(3'(k), 32'h7fff_ffff));
            pending_items.push_back(make_item(3'(k), 32'h8000_0000));
        end
        // zero vector under normalize and norm
        pending_items.push_back(make_item(KIND_NORMALIZE, 32'd0));
        pending_items.push_back(make_item(KIND_NORM, 32'd0));
        // unit-ish vectors and mixed-sign corners
        c = make_item(KIND_NORMALIZE, 32'd0);
        c.ax = 32'sd65536;
        pending_items.push_back(c);
        c.ax = -32'sd3; c.ay = 32'sd4;
        pending_items.push_back(c);
        c = make_item(KIND_CROSS, 32'h8000_0000);
        c.bx = 32'h7fff_ffff; c.by = 32'sd1; c.az = -32'sd1;
        pending_items.push_back(c);
        c = make_item(KIND_SCALE, 32'hffff_ffff);
        c.factor = 32'sd1;
        pending_items.push_back(c);
        c.kind = KIND_DOT;
        pending_items.push_back(c);
        for (int n = 0; n < 400; n++)
        begin
            c.kind = 3'($urandom_range(0, 7));
            c.ax = pick_word(); c.ay = pick_word(); c.az = pick_word();
            c.bx = pick_word(); c.by = pick_word(); c.bz = pick_word();
            c.factor = pick_word();
            pending_items.push_back(c);
        end
        stim_loaded = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: one item per start, with random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                predicted_results.push_back(vec_outcome(cmd));
            if (start && busy)
            begin
                // item not taken yet, hold it
            end
            else if (gap_left > 0 || pending_items.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                start <= 1'b1;
                cmd <= pending_items.pop_front();
                // no gap a quarter of the time, otherwise a random pause that may also be empty
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    // monitor: compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        v3alu_res_t want;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result.rx !== want.rx)
                    $error("rx expected %h got %h", want.rx, result.rx);
                if (result.ry !== want.ry)
                    $error("ry expected %h got %h", want.ry, result.ry);
                if (result.rz !== want.rz)
                    $error("rz expected %h got %h", want.rz, result.rz);
                if (result.scalar_out !== want.scalar_out)
                    $error("scalar_out expected %h got %h", want.scalar_out, result.scalar_out);
                if (result.saturated !== want.saturated)
                    $error("saturated expected %b got %b", want.saturated, result.saturated);
                if (result !== want)
                    fail_count <= fail_count + 1;
            end
        end
    end

    // end of run: everything sent, every prediction compared, then pipeline drain
    initial
    begin
        wait (stim_loaded && rst_n);
        while (pending_items.size() != 0 || start || predicted_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/v3alu_pkg.sv
sv/v3alu_lane.sv
sv/v3alu_merge.sv
sv/v3alu_sqrt_step.sv
sv/v3alu_div_step.sv
sv/vector3_alu_normalize_top.sv
sv/v3alu_checker.sv
tb/sv/tb.sv
